@@ src/plst_pkg.sv @@
// Shared types, codes and widths for the positional list store.
package plst_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int ENTRY_WIDTH_DEF = 32;

  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Per-beat command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
    logic set;
  } cell_ctl_t;

endpackage

@@ src/plst_cell.sv @@
// One list slot: holds an entry and shifts it to or from its neighbors.
module plst_cell
  import plst_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int CMP_W       = 6,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [CMP_W-1:0]       pos,
  input  logic [ENTRY_WIDTH-1:0] wr_val,
  input  logic [ENTRY_WIDTH-1:0] left_q,
  input  logic [ENTRY_WIDTH-1:0] right_q,
  output logic [ENTRY_WIDTH-1:0] q
);

  localparam logic [CMP_W-1:0] SLOT = CMP_W'(IDX + 1);

  logic [ENTRY_WIDTH-1:0] q_r;
  logic [ENTRY_WIDTH-1:0] q_nxt;
  logic                   hit;

  assign hit = (pos == SLOT);

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins) begin
      if (hit) begin
        q_nxt = wr_val;
      end else if (pos < SLOT) begin
        q_nxt = left_q;
      end
    end else if (ctl.rem) begin
      if (pos <= SLOT) begin
        q_nxt = right_q;
      end
    end else if (ctl.set && hit) begin
      q_nxt = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ src/positional_list_store.sv @@
// Top level of the positional list store: control, cell row and result register.
//
// An ordered list of up to CAPACITY entries addressed by 1-based position, kept
// in a row of cells, one entry per cell. Insert, remove, get, set and clear
// each take one input beat and give one result beat; every operation is applied
// when its beat is accepted, because all cells shift toward or away from the
// addressed slot at once, so a new beat is taken every cycle while the result
// register is free or being drained. The result is registered and appears in
// the cycle after its beat is accepted. Failed operations (position 0, past
// the length, or for insert past length+1 or a full list) and unknown codes
// return ok=0, list unchanged; read_value is zero except on a successful get.
module positional_list_store
  import plst_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[2:0], position[7:3], entry_value[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // ok[0], read_value[32:1], length[37:33], zero[39:38]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [OP_W-1:0]        in_op;
  logic [POS_W-1:0]       in_pos;
  logic [DATA_W-1:0]      in_val;
  logic [ENTRY_WIDTH-1:0] wr_val;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [IDX_W-1:0]       rd_idx;
  logic                   accept;
  logic                   in_list;
  logic                   ins_ok;
  cell_ctl_t              ctl;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic                   ok_r;
  logic                   ok_nxt;
  logic [DATA_W-1:0]      rd_r;
  logic [DATA_W-1:0]      rd_nxt;
  logic [LEN_W-1:0]       len_r;

  logic [ENTRY_WIDTH-1:0] cell_q [CAPACITY];

  assign in_op  = in_tdata[2:0];
  assign in_pos = in_tdata[7:3];
  assign in_val = in_tdata[39:8];
  assign wr_val = ENTRY_WIDTH'(in_val);

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign pos_ext = CMP_W'(in_pos);
  assign cnt_ext = CMP_W'(count_r);
  assign rd_idx  = IDX_W'(pos_ext - CMP_W'(1));
  assign in_list = (in_pos != '0) && (pos_ext <= cnt_ext);
  assign ins_ok  = (in_pos != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                   && (count_r < CNT_W'(CAPACITY));

  always_comb begin
    ctl       = '0;
    ok_nxt    = 1'b0;
    rd_nxt    = '0;
    count_nxt = count_r;
    case (op_t'(in_op))
      OP_INSERT: begin
        ok_nxt  = ins_ok;
        ctl.ins = accept && ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        ok_nxt  = in_list;
        ctl.rem = accept && in_list;
        if (in_list) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_GET: begin
        ok_nxt = in_list;
        if (in_list) begin
          rd_nxt = DATA_W'(cell_q[rd_idx]);
        end
      end
      OP_SET: begin
        ok_nxt  = in_list;
        ctl.set = accept && in_list;
      end
      OP_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_q;
    logic [ENTRY_WIDTH-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = wr_val;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    plst_cell #(
      .IDX        (i),
      .CMP_W      (CMP_W),
      .ENTRY_WIDTH(ENTRY_WIDTH)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .pos    (pos_ext),
      .wr_val (wr_val),
      .left_q (left_q),
      .right_q(right_q),
      .q      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r  <= ok_nxt;
      rd_r  <= rd_nxt;
      len_r <= LEN_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, len_r, rd_r, ok_r};

endmodule
